### hw/rtl/deque_with_delete_by_value_top_assert.svh
// Assertion macros for the deque checker.
`ifndef DEQUE_WITH_DELETE_BY_VALUE_TOP_ASSERT_SVH
`define DEQUE_WITH_DELETE_BY_VALUE_TOP_ASSERT_SVH

// Condition that holds at every clock edge out of reset.
`define DQD_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Condition that holds in the cycle after a trigger.
`define DQD_ASSERT_NEXT(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) else $error(msg);

`endif

### hw/rtl/dqd_pkg.sv
// Shared types, constants and codes for the deque with delete by value.
package dqd_pkg;

    localparam int DEPTH  = 16;
    localparam int DATA_W = 32;
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);

    typedef logic signed [DATA_W-1:0] data_t;
    typedef logic [IDX_W-1:0]         idx_t;
    typedef logic [CNT_W-1:0]         cnt_t;
    typedef logic [2:0]               op_t;
    typedef logic [1:0]               status_t;

    localparam op_t OP_PUSH_BACK  = 3'd0;
    localparam op_t OP_PUSH_FRONT = 3'd1;
    localparam op_t OP_POP_FRONT  = 3'd2;
    localparam op_t OP_POP_BACK   = 3'd3;
    localparam op_t OP_DELETE     = 3'd4;

    localparam status_t ST_OK       = 2'd0;
    localparam status_t ST_EMPTY    = 2'd1;
    localparam status_t ST_NOTFOUND = 2'd2;
    localparam status_t ST_FULL     = 2'd3;

    localparam data_t DATA_NEG_ONE = '1;
    localparam data_t DATA_ZERO    = '0;
    localparam cnt_t  CNT_FULL     = CNT_W'(DEPTH);
    localparam cnt_t  CNT_ONE      = CNT_W'(1);

    // What each cell does this cycle
    typedef enum logic [2:0] {
        CMD_HOLD,
        CMD_LOAD,       // cell at index occupancy takes the value
        CMD_SHIFT_IN,   // every cell takes its left neighbor
        CMD_SHIFT_OUT,  // every cell takes its right neighbor
        CMD_MATCH,      // cells register compare against the value
        CMD_CLOSE       // cells at or past the first match take right neighbor
    } cell_cmd_t;

    typedef struct packed {
        cell_cmd_t cmd;
        data_t     value;
        cnt_t      occ;
    } cell_ctl_t;

    typedef enum logic {
        S_IDLE,
        S_CLOSE
    } ctl_state_t;

endpackage

### hw/rtl/dqd_req_if.sv
// Request channel: op and value with valid/ready.
interface dqd_req_if;
    logic           valid;
    logic           ready;
    dqd_pkg::op_t   op;
    dqd_pkg::data_t value;

    modport source (output valid, output op, output value, input ready);
    modport sink   (input valid, input op, input value, output ready);
endinterface

### hw/rtl/dqd_rsp_if.sv
// Response channel: data and status with valid/ready.
interface dqd_rsp_if;
    logic             valid;
    logic             ready;
    dqd_pkg::data_t   data;
    dqd_pkg::status_t status;

    modport source (output valid, output data, output status, input ready);
    modport sink   (input valid, input data, input status, output ready);
endinterface

### hw/rtl/dqd_cell.sv
// One deque slot: holds an entry and a match flag, shifts with its neighbors.
module dqd_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  dqd_pkg::cell_ctl_t ctl,
    input  dqd_pkg::idx_t      idx,
    input  dqd_pkg::data_t     left_entry,
    input  dqd_pkg::data_t     right_entry,
    input  logic               hit_in,
    output logic               hit_out,
    output dqd_pkg::data_t     entry
);
    import dqd_pkg::*;

    data_t entry_reg;
    data_t entry_next;
    logic  match_reg;
    logic  match_next;
    logic  in_use;

    assign in_use  = CNT_W'(idx) < ctl.occ;
    // first match anywhere at or before this slot
    assign hit_out = hit_in | match_reg;
    assign entry   = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        match_next = match_reg;
        case (ctl.cmd)
            CMD_LOAD:
            begin
                if (CNT_W'(idx) == ctl.occ)
                begin
                    entry_next = ctl.value;
                end
            end
            CMD_SHIFT_IN:  entry_next = left_entry;
            CMD_SHIFT_OUT: entry_next = right_entry;
            CMD_MATCH:     match_next = in_use && (entry_reg == ctl.value);
            CMD_CLOSE:
            begin
                if (hit_out)
                begin
                    entry_next = right_entry;
                end
                match_next = 1'b0;
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
        end
        else
        begin
            match_reg <= match_next;
        end
    end

endmodule

### hw/rtl/deque_with_delete_by_value_top.sv
// Top level: bounded deque built from a chain of slot cells.
//
//   channel | dir | payload          | transaction
//   req     | in  | op, value        | valid && ready
//   rsp     | out | data, status     | valid && ready
//
// Push, pop and no-op requests and deletes on an empty queue finish on accept;
// a delete on a non-empty queue also passes S_CLOSE (cells compare in parallel,
// then slots at or past the first match, found via a one-bit chain through the
// cells, pull from their right neighbor). Reset clears state, occupancy, match
// flags and result valids; slot contents are never read before written.
// A two-entry result buffer lets a request be accepted while one result waits;
// req.ready drops when both entries are full or during the delete close cycle.
module deque_with_delete_by_value_top (
    input logic      clk,
    input logic      rst_n,
    dqd_req_if.sink  req,
    dqd_rsp_if.source rsp
);
    import dqd_pkg::*;

    ctl_state_t state_reg;
    ctl_state_t state_next;
    cnt_t       occ_reg;
    cnt_t       occ_next;

    logic       out_vld_reg;
    logic       out_vld_next;
    data_t      out_data_reg;
    data_t      out_data_next;
    status_t    out_status_reg;
    status_t    out_status_next;
    logic       skid_vld_reg;
    logic       skid_vld_next;
    data_t      skid_data_reg;
    data_t      skid_data_next;
    status_t    skid_status_reg;
    status_t    skid_status_next;

    logic       accept;
    logic       take;
    logic       res_vld;
    data_t      res_data;
    status_t    res_status;
    cell_ctl_t  ctl;
    cell_cmd_t  cmd;
    logic       empty;
    logic       full;
    idx_t       last_idx;
    data_t      tail_entry;

    data_t      entry_q [DEPTH];
    logic [DEPTH:0] hit_chain;

    assign req.ready = (state_reg == S_IDLE) && !skid_vld_reg;
    assign accept    = req.valid && req.ready;
    assign take      = out_vld_reg && rsp.ready;

    assign rsp.valid  = out_vld_reg;
    assign rsp.data   = out_data_reg;
    assign rsp.status = out_status_reg;

    assign empty    = (occ_reg == '0);
    assign full     = (occ_reg == CNT_FULL);
    assign last_idx = idx_t'(occ_reg - CNT_ONE);

    // back entry select, one-hot on the last occupied slot
    always_comb
    begin
        tail_entry = DATA_ZERO;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (idx_t'(i) == last_idx)
            begin
                tail_entry = tail_entry | entry_q[i];
            end
        end
    end

    assign ctl.cmd   = cmd;
    assign ctl.value = req.value;
    assign ctl.occ   = occ_reg;

    assign hit_chain[0] = 1'b0;

    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        data_t left_w;
        data_t right_w;

        if (g == 0)
        begin : g_first
            assign left_w = req.value;
        end
        else
        begin : g_mid_l
            assign left_w = entry_q[g-1];
        end

        if (g == DEPTH - 1)
        begin : g_last
            assign right_w = entry_q[g];
        end
        else
        begin : g_mid_r
            assign right_w = entry_q[g+1];
        end

        dqd_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctl         (ctl),
            .idx         (idx_t'(g)),
            .left_entry  (left_w),
            .right_entry (right_w),
            .hit_in      (hit_chain[g]),
            .hit_out     (hit_chain[g+1]),
            .entry       (entry_q[g])
        );
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && (req.op == OP_DELETE) && !empty)
                begin
                    state_next = S_CLOSE;
                end
            end
            S_CLOSE: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // request decode, cell command and result
    always_comb
    begin
        cmd        = CMD_HOLD;
        occ_next   = occ_reg;
        res_vld    = 1'b0;
        res_data   = DATA_ZERO;
        res_status = ST_OK;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_vld = 1'b1;
                    case (req.op)
                        OP_PUSH_BACK, OP_PUSH_FRONT:
                        begin
                            if (full)
                            begin
                                res_status = ST_FULL;
                            end
                            else
                            begin
                                cmd      = (req.op == OP_PUSH_BACK) ? CMD_LOAD
                                                                    : CMD_SHIFT_IN;
                                occ_next = occ_reg + CNT_ONE;
                            end
                        end
                        OP_POP_FRONT, OP_POP_BACK:
                        begin
                            if (empty)
                            begin
                                res_data   = DATA_NEG_ONE;
                                res_status = ST_EMPTY;
                            end
                            else
                            begin
                                if (req.op == OP_POP_FRONT)
                                begin
                                    cmd      = CMD_SHIFT_OUT;
                                    res_data = entry_q[0];
                                end
                                else
                                begin
                                    res_data = tail_entry;
                                end
                                occ_next = occ_reg - CNT_ONE;
                            end
                        end
                        OP_DELETE:
                        begin
                            if (empty)
                            begin
                                res_status = ST_EMPTY;
                            end
                            else
                            begin
                                cmd     = CMD_MATCH;
                                res_vld = 1'b0;
                            end
                        end
                        default:
                        begin
                            res_status = ST_OK;
                        end
                    endcase
                end
            end
            S_CLOSE:
            begin
                cmd     = CMD_CLOSE;
                res_vld = 1'b1;
                if (hit_chain[DEPTH])
                begin
                    occ_next = occ_reg - CNT_ONE;
                end
                else
                begin
                    res_status = ST_NOTFOUND;
                end
            end
            default:
            begin
                cmd = CMD_HOLD;
            end
        endcase
    end

    // two-entry result buffer
    always_comb
    begin
        out_vld_next     = out_vld_reg;
        out_data_next    = out_data_reg;
        out_status_next  = out_status_reg;
        skid_vld_next    = skid_vld_reg;
        skid_data_next   = skid_data_reg;
        skid_status_next = skid_status_reg;
        if (take)
        begin
            if (skid_vld_reg)
            begin
                out_data_next   = skid_data_reg;
                out_status_next = skid_status_reg;
                skid_vld_next   = 1'b0;
            end
            else
            begin
                out_vld_next = 1'b0;
            end
        end
        if (res_vld)
        begin
            if (!out_vld_reg || (take && !skid_vld_reg))
            begin
                out_vld_next    = 1'b1;
                out_data_next   = res_data;
                out_status_next = res_status;
            end
            else
            begin
                skid_vld_next    = 1'b1;
                skid_data_next   = res_data;
                skid_status_next = res_status;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            occ_reg      <= '0;
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            occ_reg      <= occ_next;
            out_vld_reg  <= out_vld_next;
            skid_vld_reg <= skid_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg    <= out_data_next;
        out_status_reg  <= out_status_next;
        skid_data_reg   <= skid_data_next;
        skid_status_reg <= skid_status_next;
    end

endmodule

### hw/rtl/dqd_checker.sv
// Port-level checks for the deque, bound to the top level.
`include "deque_with_delete_by_value_top_assert.svh"

module dqd_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             req_valid,
    input logic             req_ready,
    input dqd_pkg::op_t     req_op,
    input logic             rsp_valid,
    input logic             rsp_ready,
    input dqd_pkg::data_t   rsp_data,
    input dqd_pkg::status_t rsp_status
);
    import dqd_pkg::*;

    logic push_accept;
    assign push_accept = req_valid && req_ready
                         && ((req_op == OP_PUSH_BACK) || (req_op == OP_PUSH_FRONT));

    // empty status carries -1 for a pop and 0 for a delete
    `DQD_ASSERT_ALWAYS(a_empty_data,
        !(rsp_valid && (rsp_status == ST_EMPTY))
        || (rsp_data == DATA_NEG_ONE) || (rsp_data == DATA_ZERO),
        "empty status with unexpected data")

    // full and not-found results never carry data
    `DQD_ASSERT_ALWAYS(a_fail_zero,
        !(rsp_valid && ((rsp_status == ST_FULL) || (rsp_status == ST_NOTFOUND)))
        || (rsp_data == DATA_ZERO),
        "failed request with nonzero data")

    // a result is waiting on the cycle after a push transaction
    `DQD_ASSERT_NEXT(a_push_result, push_accept, rsp_valid,
        "push transaction gave no result")

    `DQD_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready,
        rsp_valid && $stable(rsp_data) && $stable(rsp_status),
        "stalled result changed")

endmodule

bind deque_with_delete_by_value_top dqd_checker u_dqd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .req_op     (req.op),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_data   (rsp.data),
    .rsp_status (rsp.status)
);
